FILE: rtl/core/bcba_pkg.sv
// shared widths, command and status codes, microcode step and branch codes
package bcba_pkg;

    // item field widths
    localparam int CMD_W   = 2;
    localparam int START_W = 10;
    localparam int LEN_W   = 11;
    localparam int STAT_W  = 2;
    localparam int FOUND_W = 10;

    // default map geometry
    localparam int DEF_BLOCK_COUNT = 1024;
    localparam int DEF_WORD_BITS   = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MARK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

    // microcode widths
    localparam int OP_W = 4;
    localparam int PC_W = 4;
    localparam int BR_W = 2;

    typedef logic [OP_W-1:0] t_op;
    typedef logic [PC_W-1:0] t_pc;
    typedef logic [BR_W-1:0] t_br;

    // datapath operations, one per control word
    localparam t_op OP_CLR   = 4'd0;
    localparam t_op OP_IDLE  = 4'd1;
    localparam t_op OP_DEC   = 4'd2;
    localparam t_op OP_USED  = 4'd3;
    localparam t_op OP_FREE  = 4'd4;
    localparam t_op OP_AFND  = 4'd5;
    localparam t_op OP_MSKIP = 4'd6;
    localparam t_op OP_MWR   = 4'd7;
    localparam t_op OP_REPLY = 4'd8;

    // program step addresses
    localparam t_pc P_CLR   = 4'd0;
    localparam t_pc P_IDLE  = 4'd1;
    localparam t_pc P_DEC   = 4'd2;
    localparam t_pc P_USED  = 4'd3;
    localparam t_pc P_FREE  = 4'd4;
    localparam t_pc P_AFND  = 4'd5;
    localparam t_pc P_MSKIP = 4'd6;
    localparam t_pc P_MWR   = 4'd7;
    localparam t_pc P_REPLY = 4'd8;

    // branch codes: two-way steps
    localparam t_br BR_WAIT = 2'd0;
    localparam t_br BR_GO   = 2'd1;
    // branch codes: decode
    localparam t_br BR_D_BAD   = 2'd0;
    localparam t_br BR_D_ALLOC = 2'd1;
    localparam t_br BR_D_RANGE = 2'd2;
    // branch codes: scan for used bit
    localparam t_br BR_U_GAP  = 2'd0;
    localparam t_br BR_U_ADV  = 2'd1;
    localparam t_br BR_U_HIT  = 2'd2;
    localparam t_br BR_U_MISS = 2'd3;
    // branch codes: scan for free bit
    localparam t_br BR_F_RUN  = 2'd0;
    localparam t_br BR_F_ADV  = 2'd1;
    localparam t_br BR_F_MISS = 2'd2;

endpackage

FILE: rtl/core/bitmap_contiguous_block_allocator.sv
// bitmap first-fit contiguous block allocator, top level with datapath and map memory
//
// One used/free bit per block, WORD_BITS bits to a word of an internal memory.
// Input channel (i_valid / o_stall): command, start_block, run_length; a transfer
// happens on a clock edge with i_valid high and o_stall low. Allocate finds the
// lowest free run of run_length blocks, marks it used and returns its start;
// mark and release set or clear a range. Output channel (o_valid / i_stall)
// carries status and found_start from an output register, so the next command is
// taken while a result still waits; a stalled result holds until taken.
// After reset a clearing pass writes zero to every word, with o_stall high. A
// rejected command goes from its transfer through the decode and reply steps to
// o_valid. Allocate steps word by word through the map and over each used run and
// each free run, takes one step to latch the run, then runs the marking pass.
// Mark, release and the allocate marking pass step over the words before the
// range, read the first word in it, then read-modify-write each word in the range
// in turn (a read-modify-write of the map memory), with dispatch and reply steps.
// One command is in work at a time; o_stall stays high until its reply step has
// loaded the output register.
module bitmap_contiguous_block_allocator #(
    parameter int BLOCK_COUNT = bcba_pkg::DEF_BLOCK_COUNT,
    parameter int WORD_BITS   = bcba_pkg::DEF_WORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bcba_pkg::CMD_W-1:0]    i_command,
    input  logic [bcba_pkg::START_W-1:0]  i_start_block,
    input  logic [bcba_pkg::LEN_W-1:0]    i_run_length,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bcba_pkg::STAT_W-1:0]   o_status,
    output logic [bcba_pkg::FOUND_W-1:0]  o_found_start
);
    import bcba_pkg::*;

    localparam int WORD_COUNT = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int POS_W      = $clog2(WORD_BITS);
    localparam int CNT_W      = $clog2(BLOCK_COUNT + WORD_BITS + 1);
    localparam int SUM_W      = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int PAD_BITS   = WORD_COUNT * WORD_BITS - BLOCK_COUNT;

    localparam logic [WORD_BITS-1:0] ONES      = '1;
    localparam logic [WORD_BITS-1:0] PAD_MASK  = ~(ONES >> PAD_BITS);
    localparam logic [CNT_W-1:0]     WB_CNT    = CNT_W'(WORD_BITS);
    localparam logic [SUM_W-1:0]     BC_SUM    = SUM_W'(BLOCK_COUNT);
    localparam logic [WIDX_W-1:0]    LAST_WIDX = WIDX_W'(WORD_COUNT - 1);
    localparam logic [POS_W-1:0]     LAST_POS  = POS_W'(WORD_BITS - 1);

    // lowest set bit of a word
    function automatic logic [POS_W-1:0] f_lowest(input logic [WORD_BITS-1:0] v);
        logic [POS_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = POS_W'(i);
            end
        end
        return idx;
    endfunction

    // sequencer link
    t_op uop;
    t_br br;

    // command registers
    logic [CMD_W-1:0]   r_cmd,   n_cmd;
    logic [START_W-1:0] r_start, n_start;
    logic [LEN_W-1:0]   r_len,   n_len;
    logic               r_set,   n_set;
    // work registers
    logic [STAT_W-1:0]  r_status, n_status;
    logic [CNT_W-1:0]   r_found,  n_found;
    logic [WIDX_W-1:0]  r_widx,   n_widx;
    logic [CNT_W-1:0]   r_base,   n_base;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [CNT_W-1:0]   r_run,    n_run;
    logic [CNT_W-1:0]   r_cand,   n_cand;
    logic [CNT_W-1:0]   r_lo,     n_lo;
    logic [CNT_W-1:0]   r_hi,     n_hi;
    // output register
    logic               r_ovalid;
    logic [STAT_W-1:0]  r_ostatus;
    logic [FOUND_W-1:0] r_ofound;
    logic               out_load;

    // map memory
    logic [WORD_BITS-1:0] r_mem [WORD_COUNT];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [WIDX_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [WIDX_W-1:0]    mem_raddr;

    // datapath terms
    logic                 accept;
    logic                 is_last;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] pos_mask;
    logic [WORD_BITS-1:0] used_m;
    logic [WORD_BITS-1:0] free_m;
    logic [POS_W-1:0]     low_idx;
    logic [WIDX_W-1:0]    widx_next;
    logic [CNT_W-1:0]     base_next;
    logic [CNT_W-1:0]     run_gap;
    logic [CNT_W-1:0]     run_tail;
    logic                 hit_gap;
    logic                 hit_tail;
    logic [SUM_W-1:0]     sum_range;
    logic                 cmd_range;
    logic                 bad;
    logic [CNT_W-1:0]     hi_alloc;
    logic [POS_W-1:0]     lo_bit;
    logic [POS_W-1:0]     hi_bit;
    logic                 hi_in;
    logic [WORD_BITS-1:0] wmask;
    logic [WORD_BITS-1:0] wnew;

    bcba_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_br    (br),
        .o_op    (uop)
    );

    // handshake
    assign o_stall       = (uop != OP_IDLE);
    assign accept        = i_valid && !o_stall;
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_found_start = r_ofound;

    // word under scan, blocks past the map read as used
    assign is_last   = (r_widx == LAST_WIDX);
    assign word      = r_rdata | (is_last ? PAD_MASK : '0);
    assign pos_mask  = ONES << r_pos;
    assign used_m    = word & pos_mask;
    assign free_m    = ~word & pos_mask;
    assign low_idx   = f_lowest((uop == OP_FREE) ? free_m : used_m);
    assign widx_next = r_widx + WIDX_W'(1);
    assign base_next = r_base + WB_CNT;

    // run length so far against requested length
    assign run_gap  = r_run + (CNT_W'(low_idx) - CNT_W'(r_pos));
    assign run_tail = r_run + (WB_CNT - CNT_W'(r_pos));
    assign hit_gap  = SUM_W'(run_gap) >= SUM_W'(r_len);
    assign hit_tail = SUM_W'(run_tail) >= SUM_W'(r_len);

    // command checks
    assign sum_range = SUM_W'(r_start) + SUM_W'(r_len);
    assign cmd_range = (r_cmd == CMD_MARK) || (r_cmd == CMD_RELEASE);
    assign bad = (r_len == '0)
              || !((r_cmd == CMD_ALLOC) || cmd_range)
              || ((r_cmd == CMD_ALLOC) && (SUM_W'(r_len) > BC_SUM))
              || (cmd_range && (sum_range > BC_SUM));
    assign hi_alloc = CNT_W'(SUM_W'(r_cand) + SUM_W'(r_len) - SUM_W'(1));

    // range mask within the current word
    assign lo_bit = (r_lo > r_base) ? POS_W'(r_lo - r_base) : '0;
    assign hi_in  = (r_hi < base_next);
    assign hi_bit = hi_in ? POS_W'(r_hi - r_base) : LAST_POS;
    assign wmask  = (ONES << lo_bit) & (ONES >> (LAST_POS - hi_bit));
    assign wnew   = r_set ? (r_rdata | wmask) : (r_rdata & ~wmask);

    // datapath operations
    always_comb begin
        n_cmd     = r_cmd;
        n_start   = r_start;
        n_len     = r_len;
        n_set     = r_set;
        n_status  = r_status;
        n_found   = r_found;
        n_widx    = r_widx;
        n_base    = r_base;
        n_pos     = r_pos;
        n_run     = r_run;
        n_cand    = r_cand;
        n_lo      = r_lo;
        n_hi      = r_hi;
        mem_we    = 1'b0;
        mem_waddr = r_widx;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_widx;
        out_load  = 1'b0;
        br        = BR_WAIT;
        unique case (uop)
            OP_CLR: begin
                mem_we = 1'b1;
                if (is_last) begin
                    br = BR_GO;
                end else begin
                    n_widx = widx_next;
                end
            end
            OP_IDLE: begin
                if (accept) begin
                    n_cmd   = i_command;
                    n_start = i_start_block;
                    n_len   = i_run_length;
                    br      = BR_GO;
                end
            end
            OP_DEC: begin
                n_status  = bad ? ST_BAD : ST_OK;
                n_found   = '0;
                n_widx    = '0;
                n_base    = '0;
                n_pos     = '0;
                n_run     = '0;
                n_cand    = '0;
                n_lo      = CNT_W'(r_start);
                n_hi      = CNT_W'(sum_range - SUM_W'(1));
                n_set     = (r_cmd != CMD_RELEASE);
                mem_re    = 1'b1;
                mem_raddr = '0;
                priority if (bad) begin
                    br = BR_D_BAD;
                end else if (r_cmd == CMD_ALLOC) begin
                    br = BR_D_ALLOC;
                end else begin
                    br = BR_D_RANGE;
                end
            end
            OP_USED: begin
                if (used_m == '0) begin
                    priority if (hit_tail) begin
                        br = BR_U_HIT;
                    end else if (is_last) begin
                        n_status = ST_NOFIT;
                        br       = BR_U_MISS;
                    end else begin
                        n_widx    = widx_next;
                        n_base    = base_next;
                        n_pos     = '0;
                        n_run     = run_tail;
                        mem_re    = 1'b1;
                        mem_raddr = widx_next;
                        br        = BR_U_ADV;
                    end
                end else if (hit_gap) begin
                    br = BR_U_HIT;
                end else begin
                    n_pos = low_idx;
                    br    = BR_U_GAP;
                end
            end
            OP_FREE: begin
                if (free_m == '0) begin
                    if (is_last) begin
                        n_status = ST_NOFIT;
                        br       = BR_F_MISS;
                    end else begin
                        n_widx    = widx_next;
                        n_base    = base_next;
                        n_pos     = '0;
                        mem_re    = 1'b1;
                        mem_raddr = widx_next;
                        br        = BR_F_ADV;
                    end
                end else begin
                    n_cand = r_base + CNT_W'(low_idx);
                    n_pos  = low_idx;
                    n_run  = '0;
                    br     = BR_F_RUN;
                end
            end
            OP_AFND: begin
                n_lo    = r_cand;
                n_hi    = hi_alloc;
                n_found = r_cand;
                n_widx  = '0;
                n_base  = '0;
                br      = BR_GO;
            end
            OP_MSKIP: begin
                if (base_next <= r_lo) begin
                    n_widx = widx_next;
                    n_base = base_next;
                end else begin
                    mem_re = 1'b1;
                    br     = BR_GO;
                end
            end
            OP_MWR: begin
                mem_we    = 1'b1;
                mem_wdata = wnew;
                if (hi_in) begin
                    br = BR_GO;
                end else begin
                    n_widx    = widx_next;
                    n_base    = base_next;
                    mem_re    = 1'b1;
                    mem_raddr = widx_next;
                end
            end
            OP_REPLY: begin
                if (!r_ovalid || !i_stall) begin
                    out_load = 1'b1;
                    br       = BR_GO;
                end
            end
            default: begin
                br = BR_WAIT;
            end
        endcase
    end

    // map memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_widx <= n_widx;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // work and payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_start  <= n_start;
        r_len    <= n_len;
        r_set    <= n_set;
        r_status <= n_status;
        r_found  <= n_found;
        r_base   <= n_base;
        r_pos    <= n_pos;
        r_run    <= n_run;
        r_cand   <= n_cand;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        if (out_load) begin
            r_ostatus <= r_status;
            r_ofound  <= FOUND_W'(r_found);
        end
    end

    // a result appears only from the reply step
    a_out_from_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(uop == OP_REPLY))
        else $error("result register loaded outside reply step");

    // a taken command is decoded in the next cycle
    a_dec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (uop == OP_DEC))
        else $error("accepted command not decoded");

    // the run scan only runs for allocate
    a_scan_alloc_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((uop == OP_USED) || (uop == OP_FREE)) |-> (r_cmd == CMD_ALLOC))
        else $error("run scan for a non-allocate command");

    // every marking write touches a word that overlaps the range
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop == OP_MWR) |-> ((r_lo < base_next) && (r_hi >= r_base)))
        else $error("marking write outside the range");

endmodule

FILE: rtl/core/bcba_useq.sv
// microcode sequencer: step counter, control store and four-way branch
module bcba_useq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bcba_pkg::t_br  i_br,
    output bcba_pkg::t_op  o_op
);
    import bcba_pkg::*;

    typedef struct packed {
        t_op op;
        t_pc tgt3;
        t_pc tgt2;
        t_pc tgt1;
        t_pc tgt0;
    } t_uword;

    // control store: operation plus next step for each branch code
    function automatic t_uword f_urom(input t_pc pc);
        t_uword w;
        unique case (pc)
            P_CLR:   w = '{op: OP_CLR,   tgt3: P_IDLE,  tgt2: P_IDLE,
                           tgt1: P_IDLE,  tgt0: P_CLR};
            P_IDLE:  w = '{op: OP_IDLE,  tgt3: P_IDLE,  tgt2: P_IDLE,
                           tgt1: P_DEC,   tgt0: P_IDLE};
            P_DEC:   w = '{op: OP_DEC,   tgt3: P_REPLY, tgt2: P_MSKIP,
                           tgt1: P_USED,  tgt0: P_REPLY};
            P_USED:  w = '{op: OP_USED,  tgt3: P_REPLY, tgt2: P_AFND,
                           tgt1: P_USED,  tgt0: P_FREE};
            P_FREE:  w = '{op: OP_FREE,  tgt3: P_REPLY, tgt2: P_REPLY,
                           tgt1: P_FREE,  tgt0: P_USED};
            P_AFND:  w = '{op: OP_AFND,  tgt3: P_MSKIP, tgt2: P_MSKIP,
                           tgt1: P_MSKIP, tgt0: P_MSKIP};
            P_MSKIP: w = '{op: OP_MSKIP, tgt3: P_MWR,   tgt2: P_MWR,
                           tgt1: P_MWR,   tgt0: P_MSKIP};
            P_MWR:   w = '{op: OP_MWR,   tgt3: P_REPLY, tgt2: P_REPLY,
                           tgt1: P_REPLY, tgt0: P_MWR};
            P_REPLY: w = '{op: OP_REPLY, tgt3: P_IDLE,  tgt2: P_IDLE,
                           tgt1: P_IDLE,  tgt0: P_REPLY};
            default: w = '{op: OP_IDLE,  tgt3: P_IDLE,  tgt2: P_IDLE,
                           tgt1: P_IDLE,  tgt0: P_IDLE};
        endcase
        return w;
    endfunction

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uword;

    assign uword = f_urom(r_pc);
    assign o_op  = uword.op;

    // next step from branch code
    always_comb begin
        unique case (i_br)
            2'd0:    n_pc = uword.tgt0;
            2'd1:    n_pc = uword.tgt1;
            2'd2:    n_pc = uword.tgt2;
            default: n_pc = uword.tgt3;
        endcase
    end

    // step counter, starts with the map clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= P_CLR;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

FILE: bench/testbench.sv
// self-checking testbench for the bitmap first-fit contiguous block allocator
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bcba_pkg::*;

    localparam int BLOCKS           = DEF_BLOCK_COUNT;
    localparam int MAX_LEN          = (1 << LEN_W) - 1;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int DRAIN_CYCLES     = 200;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one reply as the block returns it
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FOUND_W-1:0] found_start;
    } reply_t;

    // a run handed out by an allocate, kept so it can be released later
    typedef struct {
        int first;
        int count;
    } extent_t;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic [CMD_W-1:0]    i_command     = CMD_ALLOC;
    logic [START_W-1:0]  i_start_block = '0;
    logic [LEN_W-1:0]    i_run_length  = '0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [FOUND_W-1:0]  o_found_start;

    // predicted map: one bit per block, set means used
    bit [0:BLOCKS-1] block_used = '0;
    reply_t          pending_replies[$];
    extent_t         live_extents[$];

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int hold_left       = 0;
    int fail_count      = 0;
    int commands_sent   = 0;
    int replies_checked = 0;
    int ok_count        = 0;
    int nofit_count     = 0;
    int bad_count       = 0;
    int held_in_cycles  = 0;

    bitmap_contiguous_block_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_start_block (i_start_block),
        .i_run_length  (i_run_length),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found_start (o_found_start)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // receiver stall: random, or a counted hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // reply checker: each output transfer against the oldest prediction
    always @(posedge i_clk) begin
        reply_t want;
        if (i_rst_n && i_valid && o_stall === 1'b1 && hold_left > 0) begin
            held_in_cycles++;
        end
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with none pending: status %0d found_start %0d",
                         $time, o_status, o_found_start);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    fail_count++;
                end
                if (o_found_start !== want.found_start) begin
                    $display("%0t: found_start expected %0d actual %0d",
                             $time, want.found_start, o_found_start);
                    fail_count++;
                end
                replies_checked++;
            end
        end
    end

    // apply one command to the predicted map and return its reply
    function automatic reply_t predict_reply(input logic [CMD_W-1:0] cmd,
                                             input logic [START_W-1:0] start,
                                             input logic [LEN_W-1:0] len);
        reply_t r;
        int     count;
        int     first;
        int     run_len;
        int     hit;
        r.status      = ST_BAD;
        r.found_start = '0;
        count   = int'(len);
        first   = int'(start);
        run_len = 0;
        hit     = -1;
        if (count == 0) begin
            r.status = ST_BAD;
        end else if (cmd == CMD_ALLOC) begin
            if (count > BLOCKS) begin
                r.status = ST_BAD;
            end else begin
                // first fit: lowest start of a free run of the requested length
                for (int b = 0; b < BLOCKS && hit < 0; b++) begin
                    if (block_used[b]) begin
                        run_len = 0;
                    end else begin
                        run_len++;
                        if (run_len == count) hit = b + 1 - count;
                    end
                end
                if (hit >= 0) begin
                    for (int b = hit; b < hit + count; b++) block_used[b] = 1'b1;
                    r.status      = ST_OK;
                    r.found_start = hit[FOUND_W-1:0];
                end else begin
                    r.status = ST_NOFIT;
                end
            end
        end else if (cmd == CMD_MARK || cmd == CMD_RELEASE) begin
            if (first + count > BLOCKS) begin
                r.status = ST_BAD;
            end else begin
                for (int b = first; b < first + count; b++) block_used[b] = (cmd == CMD_MARK);
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    // offer one command, wait for its transfer, record the predicted reply
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input int start,
                                input int len);
        reply_t               r;
        logic [START_W-1:0]   start_bits;
        logic [LEN_W-1:0]     len_bits;
        start_bits = START_W'(start);
        len_bits   = LEN_W'(len);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_start_block <= start_bits;
        i_run_length  <= len_bits;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        r = predict_reply(cmd, start_bits, len_bits);
        pending_replies.push_back(r);
        commands_sent++;
        if (cmd == CMD_ALLOC && r.status == ST_OK) begin
            live_extents.push_back('{int'(r.found_start), int'(len_bits)});
        end
        case (r.status)
            ST_OK:    ok_count++;
            ST_NOFIT: nofit_count++;
            default:  bad_count++;
        endcase
    endtask

    // drop valid and wait for every pending reply
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    // random command: mostly well-formed traffic, some malformed
    task automatic pick_random_request(output logic [CMD_W-1:0] cmd,
                                       output int start,
                                       output int len);
        int      roll;
        int      pick;
        int      first;
        extent_t ext;
        roll  = $urandom_range(0, 99);
        cmd   = CMD_ALLOC;
        start = $urandom_range(0, BLOCKS - 1);
        len   = 1;
        if (roll < 40 || (roll < 58 && live_extents.size() == 0)) begin
            // allocate, mostly short runs
            pick = $urandom_range(0, 99);
            if (pick < 70) len = $urandom_range(1, 32);
            else if (pick < 95) len = $urandom_range(33, 200);
            else len = $urandom_range(201, BLOCKS);
        end else if (roll < 58) begin
            // give back a run handed out earlier
            pick = $urandom_range(0, live_extents.size() - 1);
            ext  = live_extents[pick];
            live_extents.delete(pick);
            cmd   = CMD_RELEASE;
            start = ext.first;
            len   = ext.count;
        end else if (roll < 60) begin
            // clear the whole map
            cmd   = CMD_RELEASE;
            start = 0;
            len   = BLOCKS;
            live_extents.delete();
        end else if (roll < 85) begin
            // legal mark or release range
            first = $urandom_range(0, BLOCKS - 1);
            cmd   = (roll < 75) ? CMD_MARK : CMD_RELEASE;
            start = first;
            len   = $urandom_range(1, (BLOCKS - first < 64) ? BLOCKS - first : 64);
        end else begin
            case ($urandom_range(0, 4))
                0: begin
                    cmd = CMD_W'($urandom_range(int'(CMD_ALLOC), int'(CMD_UNUSED)));
                    len = 0;
                end
                1: len = $urandom_range(BLOCKS + 1, MAX_LEN);
                2: begin
                    first = $urandom_range(0, BLOCKS - 1);
                    cmd   = $urandom_range(0, 1) ? CMD_MARK : CMD_RELEASE;
                    start = first;
                    len   = $urandom_range(BLOCKS + 1 - first, MAX_LEN);
                end
                3: begin
                    cmd = CMD_UNUSED;
                    len = $urandom_range(0, MAX_LEN);
                end
                default: begin
                    cmd = CMD_W'($urandom_range(int'(CMD_ALLOC), int'(CMD_UNUSED)));
                    len = $urandom_range(0, MAX_LEN);
                end
            endcase
        end
    endtask

    // full-map allocate, overlong and zero lengths, repeat mark and release
    task automatic test_whole_map();
        send_request(CMD_ALLOC, 0, BLOCKS);
        send_request(CMD_ALLOC, 0, 1);
        send_request(CMD_MARK, 10, 5);
        send_request(CMD_RELEASE, 0, BLOCKS);
        send_request(CMD_RELEASE, 5, 5);
        send_request(CMD_ALLOC, 0, MAX_LEN);
        send_request(CMD_ALLOC, 0, BLOCKS + 1);
        send_request(CMD_ALLOC, 0, 0);
    endtask

    // range checks at the map end and a run that ends on the last block
    task automatic test_range_limits();
        send_request(CMD_MARK, BLOCKS - 1, 1);
        send_request(CMD_MARK, BLOCKS - 1, 2);
        send_request(CMD_RELEASE, BLOCKS - 1, BLOCKS);
        send_request(CMD_MARK, 0, 0);
        send_request(CMD_RELEASE, 512, 0);
        send_request(CMD_MARK, 1, BLOCKS - 2);
        send_request(CMD_ALLOC, 0, 2);
        send_request(CMD_ALLOC, 0, 1);
        send_request(CMD_RELEASE, 990, 34);
        send_request(CMD_ALLOC, 0, 34);
        send_request(CMD_RELEASE, 0, BLOCKS);
    endtask

    // first fit skips a hole that is too short
    task automatic test_first_fit_order();
        send_request(CMD_MARK, 0, 3);
        send_request(CMD_MARK, 5, 2);
        send_request(CMD_ALLOC, 0, 3);
        send_request(CMD_ALLOC, 0, 2);
        send_request(CMD_RELEASE, 0, BLOCKS);
    endtask

    // unused command code is rejected
    task automatic test_unused_code();
        send_request(CMD_UNUSED, 0, 5);
        send_request(CMD_UNUSED, BLOCKS - 1, MAX_LEN);
        send_request(CMD_UNUSED, 7, 0);
    endtask

    // one random phase with the given idling mix
    task automatic test_random_traffic(input int idle_pct_in, input int stall_pct_in,
                                       input int count);
        logic [CMD_W-1:0] cmd;
        int               start;
        int               len;
        wait_drained();
        send_idle_pct = idle_pct_in;
        stall_pct     = stall_pct_in;
        repeat (count) begin
            pick_random_request(cmd, start, len);
            send_request(cmd, start, len);
        end
        wait_drained();
    endtask

    // long receiver hold-off while commands keep coming, so the input backs up
    task automatic test_backpressure();
        logic [CMD_W-1:0] cmd;
        int               start;
        int               len;
        wait_drained();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = HOLD_OFF_CYCLES;
        repeat (12) begin
            pick_random_request(cmd, start, len);
            send_request(cmd, start, len);
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_whole_map();
        test_range_limits();
        test_first_fit_order();
        test_unused_code();
        test_random_traffic(0, 0, RANDOM_PER_PHASE);
        test_random_traffic(75, 0, RANDOM_PER_PHASE);
        test_random_traffic(0, 75, RANDOM_PER_PHASE);
        test_backpressure();
        test_random_traffic(23, 23, RANDOM_PER_PHASE);
        stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run covered %0d commands, %0d replies checked: %0d ok, %0d no fit, %0d rejected",
                 commands_sent, replies_checked, ok_count, nofit_count, bad_count);
        $display("idling mixes none/sender/receiver/both, input held back %0d cycles in hold-off",
                 held_in_cycles);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("timeout with %0d replies pending", pending_replies.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/bcba_pkg.sv
rtl/core/bcba_useq.sv
rtl/core/bitmap_contiguous_block_allocator.sv
bench/testbench.sv
